/* design/segmented_tx_ring_buffer_defines.svh */
// ----------------------------------------------------------------------------
// segmented_tx_ring_buffer_defines
// Assertion macros shared by the segmented transmit ring buffer.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_TX_RING_BUFFER_DEFINES_SVH
`define SEGMENTED_TX_RING_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SEGTX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define SEGTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEGTX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SEGTX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/stxrb_pkg.sv */
// ----------------------------------------------------------------------------
// stxrb_pkg
// Sizes, codes and shared types of the segmented transmit ring buffer.
// ----------------------------------------------------------------------------
package stxrb_pkg;

  // storage sizes
  localparam int unsigned BUF_BYTES = 1024;
  localparam int unsigned SEG_SLOTS = 16;

  // derived widths
  localparam int unsigned PTR_W    = $clog2(BUF_BYTES);
  localparam int unsigned LEN_W    = PTR_W + 1;
  localparam int unsigned SLOT_W   = $clog2(SEG_SLOTS);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned QCNT_W   = 4;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_FETCH = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_SEG_FULL = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOT_OPEN = 3'd5
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EXEC
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // next descriptor slot around the ring
  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(SEG_SLOTS - 1)) return '0;
    return s + 1'b1;
  endfunction

endpackage

/* design/stxrb_ram.sv */
// ----------------------------------------------------------------------------
// stxrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stxrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/stxrb_ctrl.sv */
// ----------------------------------------------------------------------------
// stxrb_ctrl
// Item sequencer: accept, placement and read setup, then update and result.
// ----------------------------------------------------------------------------
module stxrb_ctrl
  import stxrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (dp_status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.calc    = 1'b0;
    cmd_o.exec    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
      end
      S_EXEC: begin
        cmd_o.exec = dp_status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* design/stxrb_datapath.sv */
// ----------------------------------------------------------------------------
// stxrb_datapath
// Ring state, descriptor slots, byte RAM, placement logic and result register.
// ----------------------------------------------------------------------------
`include "segmented_tx_ring_buffer_defines.svh"

module stxrb_datapath
  import stxrb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          dp_status_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [LEN_W-1:0]    msg_length_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    write_position_o,
  output logic [BYTE_W-1:0]   tx_byte_o,
  output logic                tx_valid_o,
  output logic                segment_last_o,
  output logic [QCNT_W-1:0]   queued_segments_o
);

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [LEN_W-1:0]  len_q;
  logic [BYTE_W-1:0] byte_q;

  // descriptor slots
  logic [PTR_W-1:0] seg_start_q [SEG_SLOTS];
  logic [LEN_W-1:0] seg_len_q   [SEG_SLOTS];

  // ring and open message state
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [LEN_W-1:0]  roff_q, roff_d;
  logic [PTR_W-1:0]  open_start_q, open_start_d;
  logic [LEN_W-1:0]  open_len_q, open_len_d;
  logic [LEN_W-1:0]  open_cnt_q, open_cnt_d;
  logic [PTR_W-1:0]  open_next_q, open_next_d;
  logic              open_q, open_d;

  // placement figures
  logic             w_gt_r_q, w_eq_r_q;
  logic [LEN_W-1:0] at_end_q, at_end_d;
  logic [PTR_W-1:0] at_start_q;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [POS_W-1:0]    out_pos_q;
  logic [BYTE_W-1:0]   out_txb_q;
  logic                out_txv_q;
  logic                out_last_q;
  logic [QCNT_W-1:0]   out_qcnt_q;

  // step results
  status_e             res_status;
  logic [PTR_W-1:0]    res_pos;
  logic [BYTE_W-1:0]   res_txb;
  logic                res_txv;
  logic                res_last;
  logic [QCNT_W-1:0]   res_qcnt;

  // misc
  logic [PTR_W-1:0]  head_start;
  logic [LEN_W-1:0]  head_len;
  logic [PTR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              queue_empty;
  logic              place_ok;
  logic [PTR_W-1:0]  place_pos;
  logic [LEN_W-1:0]  place_next;
  logic [LEN_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  roff_inc;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic              seg_wr;

  assign head_start  = seg_start_q[head_q];
  assign head_len    = seg_len_q[head_q];
  assign queue_empty = (head_q == tail_q);
  assign cnt_inc     = open_cnt_q + 1'b1;
  assign roff_inc    = roff_q + 1'b1;
  // a segment never crosses the end of the ring, so no wrap here
  assign rd_addr     = head_start + roff_q[PTR_W-1:0];
  assign ram_waddr   = open_start_q + open_cnt_q[PTR_W-1:0];

  // byte store
  stxrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      len_q  <= msg_length_i;
      byte_q <= data_byte_i;
    end
  end

  // free space around the head segment
  always_comb begin
    if (wptr_q > head_start) begin
      at_end_d = LEN_W'(BUF_BYTES) - {1'b0, wptr_q};
    end else begin
      at_end_d = {1'b0, head_start} - {1'b0, wptr_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      w_gt_r_q   <= (wptr_q > head_start);
      w_eq_r_q   <= (wptr_q == head_start);
      at_end_q   <= at_end_d;
      at_start_q <= (wptr_q > head_start) ? head_start : '0;
    end
  end

  // placement of a new message
  always_comb begin
    place_ok   = 1'b1;
    place_pos  = '0;
    place_next = len_q;
    if (!queue_empty) begin
      if (w_eq_r_q) begin
        place_ok = 1'b0;
      end else if (len_q <= at_end_q) begin
        place_pos  = wptr_q;
        place_next = {1'b0, wptr_q} + len_q;
      end else if (w_gt_r_q && (len_q <= {1'b0, at_start_q})) begin
        place_pos  = '0;
        place_next = len_q;
      end else begin
        place_ok = 1'b0;
      end
    end
  end

  // step update and result
  always_comb begin
    res_status   = ST_OK;
    res_pos      = '0;
    res_txb      = '0;
    res_txv      = 1'b0;
    res_last     = 1'b0;
    head_d       = head_q;
    tail_d       = tail_q;
    wptr_d       = wptr_q;
    roff_d       = roff_q;
    open_start_d = open_start_q;
    open_len_d   = open_len_q;
    open_cnt_d   = open_cnt_q;
    open_next_d  = open_next_q;
    open_d       = open_q;
    ram_we       = 1'b0;
    seg_wr       = 1'b0;
    case (op_q)
      OP_BEGIN: begin
        if ((len_q == '0) || (len_q > LEN_W'(BUF_BYTES))) begin
          res_status = ST_BAD_LEN;
        end else if (slot_next(tail_q) == head_q) begin
          res_status = ST_SEG_FULL;
        end else if (!place_ok) begin
          res_status = ST_NO_SPACE;
        end else begin
          res_pos      = place_pos;
          open_start_d = place_pos;
          open_len_d   = len_q;
          open_cnt_d   = '0;
          open_next_d  = (place_next >= LEN_W'(BUF_BYTES)) ? '0 : place_next[PTR_W-1:0];
          open_d       = 1'b1;
        end
      end
      OP_DATA: begin
        if (!open_q) begin
          res_status = ST_NOT_OPEN;
        end else begin
          ram_we = 1'b1;
          if (cnt_inc >= open_len_q) begin
            // last byte commits the message
            seg_wr     = 1'b1;
            tail_d     = slot_next(tail_q);
            wptr_d     = open_next_q;
            open_d     = 1'b0;
            open_cnt_d = '0;
          end else begin
            open_cnt_d = cnt_inc;
          end
        end
      end
      OP_FETCH: begin
        if (queue_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_txb = rd_data;
          res_txv = 1'b1;
          if (roff_inc >= head_len) begin
            res_last = 1'b1;
            roff_d   = '0;
            head_d   = slot_next(head_q);
          end else begin
            roff_d = roff_inc;
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // committed segments after the step
  always_comb begin
    if (tail_d >= head_d) begin
      res_qcnt = QCNT_W'(tail_d - head_d);
    end else begin
      res_qcnt = QCNT_W'(SEG_SLOTS + tail_d - head_d);
    end
  end

  // descriptor write on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && seg_wr) begin
      seg_start_q[tail_q] <= open_start_q;
      seg_len_q[tail_q]   <= open_len_q;
    end
  end

  // ring control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      wptr_q       <= '0;
      roff_q       <= '0;
      open_start_q <= '0;
      open_len_q   <= '0;
      open_cnt_q   <= '0;
      open_next_q  <= '0;
      open_q       <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      wptr_q       <= wptr_d;
      roff_q       <= roff_d;
      open_start_q <= open_start_d;
      open_len_q   <= open_len_d;
      open_cnt_q   <= open_cnt_d;
      open_next_q  <= open_next_d;
      open_q       <= open_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= res_status;
      out_pos_q    <= POS_W'(res_pos);
      out_txb_q    <= res_txb;
      out_txv_q    <= res_txv;
      out_last_q   <= res_last;
      out_qcnt_q   <= res_qcnt;
    end
  end

  assign dp_status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign write_position_o     = out_pos_q;
  assign tx_byte_o            = out_txb_q;
  assign tx_valid_o           = out_txv_q;
  assign segment_last_o       = out_last_q;
  assign queued_segments_o    = out_qcnt_q;

  // checks
  `SEGTX_ASSERT_IMP(a_empty_no_offset, clk_i, rst_ni, head_q == tail_q, roff_q == '0, "fetch offset left on an empty queue")
  `SEGTX_ASSERT_IMP(a_open_below_length, clk_i, rst_ni, open_q, open_cnt_q < open_len_q, "open message count reached its length")
  `SEGTX_ASSERT_IMP(a_last_has_byte, clk_i, rst_ni, out_valid_q && out_last_q, out_txv_q, "segment end flagged without a byte")
  `SEGTX_ASSERT_NEXT(a_commit_one_slot, clk_i, rst_ni, cmd_i.exec && seg_wr, tail_q == slot_next($past(tail_q)), "commit did not advance the tail by one slot")

endmodule

/* design/segmented_tx_ring_buffer.sv */
// ----------------------------------------------------------------------------
// segmented_tx_ring_buffer
// Transmit buffer holding whole messages in a byte ring with a descriptor ring.
// ----------------------------------------------------------------------------
// Each item passes through the sequencer states in order: taking the item,
// sizing the free space around the head segment and addressing the byte RAM,
// then updating the rings and loading the result register; the update waits
// while the result register holds a result not yet taken. No new item is
// taken before the current one has loaded its result. The byte RAM read and
// the placement compare are registered. The result register lets the next
// item be taken while a result waits; a stalled result stalls the block one
// item later. Stored bytes and descriptors are not cleared at reset and need
// no clearing pass: only written entries are ever read. Codes on tuser[1:0]:
// 0 begin message (length in msg_length), 1 data byte, 2 fetch next byte.
// Result status 0 ok, 1 segment ring full, 2 no contiguous space, 3 bad
// length, 4 queue empty, 5 no message open.
module segmented_tx_ring_buffer
  import stxrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // msg_length[10:0], data_byte[18:11], zero pad
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // write_position[9:0], tx_byte[17:10],
                                      // queued_segments[21:18], zero pad
  output logic [3:0]  m_axis_tuser,   // status[2:0], tx_valid[3]
  output logic        m_axis_tlast    // segment_last
);

  ctrl_cmd_t           cmd;
  dp_status_t          dp_status;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    write_position;
  logic [BYTE_W-1:0]   tx_byte;
  logic                tx_valid;
  logic [QCNT_W-1:0]   queued_segments;

  // sequencer
  stxrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  // rings, store and result register
  stxrb_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .dp_status_o       (dp_status),
    .op_i              (s_axis_tuser),
    .msg_length_i      (s_axis_tdata[10:0]),
    .data_byte_i       (s_axis_tdata[18:11]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .status_o          (status),
    .write_position_o  (write_position),
    .tx_byte_o         (tx_byte),
    .tx_valid_o        (tx_valid),
    .segment_last_o    (m_axis_tlast),
    .queued_segments_o (queued_segments)
  );

  // result packing
  assign m_axis_tdata = {2'b00, queued_segments, tx_byte, write_position};
  assign m_axis_tuser = {tx_valid, status};

endmodule
